/* sv/nwom_pkg.sv */
// Shared constants and calendar tables for the nth-weekday-of-month block.
// No dependencies; imported by the top level, both checkers and the testbench top.
`timescale 1ns / 1ps

package nwom_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned ORD_W   = 3;
  localparam int unsigned WDAY_W  = 3;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned CFG_W   = 4;

  localparam logic [YEAR_W-1:0] EPOCH_YEAR = 14'd1850;

  // Reciprocal of 25 scaled by 2^17; exact floor for dividends below 43690.
  localparam logic [12:0] RECIP_25    = 13'd5243;
  localparam int unsigned RECIP_SHIFT = 17;
  localparam int unsigned PROD_W      = 25;

  typedef enum logic [1:0] {
    CFG_TARGET_MONTH   = 2'd0,
    CFG_WEEK_ORDINAL   = 2'd1,
    CFG_TARGET_WEEKDAY = 2'd2
  } cfg_index_t;

  // Day count from January 1 to the 1st of month m, reduced mod 7.
  // Month 0 stands for any month code outside 1..12.
  function automatic logic [2:0] month_start_mod7(input logic [MONTH_W-1:0] m);
    logic [2:0] r;
    case (m)
      4'd0:    r = 3'd0;
      4'd1:    r = 3'd0;
      4'd2:    r = 3'd3;
      4'd3:    r = 3'd3;
      4'd4:    r = 3'd6;
      4'd5:    r = 3'd1;
      4'd6:    r = 3'd4;
      4'd7:    r = 3'd6;
      4'd8:    r = 3'd2;
      4'd9:    r = 3'd5;
      4'd10:   r = 3'd0;
      4'd11:   r = 3'd3;
      4'd12:   r = 3'd5;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // Length of month m in a common year.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] r;
    case (m)
      4'd2:                  r = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
      default:               r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

/* sv/nth_weekday_of_month_top.sv */
// Top level of the nth-weekday-of-month block: four-stage pipeline and
// configuration registers. Depends on nwom_pkg.
`timescale 1ns / 1ps

// Usage
// - Request channel (req_valid, req_stall, year): one Gregorian year per
//   transfer. A transfer happens at a clock edge with req_valid high and
//   req_stall low.
// - Response channel (rsp_valid, rsp_stall, year_echo, found, day_of_month):
//   exactly one result per request, in order.
// - Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data): index 0
//   target month, 1 week ordinal, 2 target weekday; other indexes are
//   ignored. cfg_ready is always high. Write only while the pipeline is empty.
// - Throughput is one year per cycle while the receiver does not stall. The
//   four registered stages are: constant reciprocal multiplies, leap and
//   day-count sums, mod-7 fold, and the final weekday offset and
//   month-length compare.
// - When the receiver stalls, the stages fill behind the output register and
//   req_stall rises once all four hold data; nothing is dropped or repeated.
// - Synchronous reset empties the pipeline and sets month 1, ordinal 1,
//   weekday 1.

module nth_weekday_of_month_top
  import nwom_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  logic [YEAR_W-1:0]   year,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output logic [YEAR_W-1:0]   year_echo,
  output logic                found,
  output logic [DAY_W-1:0]    day_of_month,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  logic [MONTH_W-1:0] target_month;
  logic [ORD_W-1:0]   week_ordinal;
  logic [WDAY_W-1:0]  target_weekday;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_month   <= 4'd1;
      week_ordinal   <= 3'd1;
      target_weekday <= 3'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TARGET_MONTH:   target_month   <= cfg_data[MONTH_W-1:0];
        CFG_WEEK_ORDINAL:   week_ordinal   <= cfg_data[ORD_W-1:0];
        CFG_TARGET_WEEKDAY: target_weekday <= cfg_data[WDAY_W-1:0];
        default: ;
      endcase
    end
  end

  // Month codes outside 1..12 behave as a 31-day month starting on Jan 1.
  logic [MONTH_W-1:0] month_sel;
  assign month_sel = (target_month inside {[4'd1:4'd12]}) ? target_month : 4'd0;

  // Stage enables: a stage loads when it is empty or its successor loads.
  logic v1, v2, v3;
  logic en1, en2, en3, en4;
  assign en4 = !rsp_valid || !rsp_stall;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign req_stall = !en1;

  // Stage 1: previous year and the reciprocal products for /100 and /400.
  logic [YEAR_W-1:0] s1_year, s1_prev;
  logic [PROD_W-1:0] s1_p100, s1_p400;
  logic [YEAR_W-1:0] prev_year;
  assign prev_year = year - 14'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_year <= year;
      s1_prev <= prev_year;
      s1_p100 <= PROD_W'(prev_year[YEAR_W-1:2]) * PROD_W'(RECIP_25);
      s1_p400 <= PROD_W'(prev_year[YEAR_W-1:4]) * PROD_W'(RECIP_25);
    end
  end

  // Stage 2: leap count up to the previous year, and the leap flag. Since
  // 365 is 1 mod 7, the weekday depends on prev + leaps only.
  logic [11:0] q4, q100, q400, r100, r400;
  logic [11:0] leaps;
  logic        leap_c;
  logic [14:0] s2_sum;
  logic [YEAR_W-1:0] s2_year;
  logic        s2_leap;

  always_comb begin
    q4    = s1_prev[YEAR_W-1:2];
    q100  = 12'(s1_p100[PROD_W-1:RECIP_SHIFT]);
    q400  = 12'(s1_p400[PROD_W-1:RECIP_SHIFT]);
    r100  = q4 - 12'(q100 * 12'd25);
    r400  = 12'(s1_prev[YEAR_W-1:4]) - 12'(q400 * 12'd25);
    leaps = q4 - q100 + q400;
    // For a multiple of 4, the year is a century exactly when the quarter
    // of the previous year leaves 24 mod 25; likewise for 400 with /16.
    leap_c = (s1_year[1:0] == 2'd0) &&
             ((r100 != 12'd24) || ((s1_year[3:0] == 4'd0) && (r400 == 12'd24)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_year <= s1_year;
      s2_sum  <= 15'(s1_prev) + 15'(leaps);
      s2_leap <= leap_c;
    end
  end

  // Stage 3: add the month offset and fold to a residue mod 7 (8 is 1 mod 7).
  logic [14:0] day_sum;
  logic [5:0]  fold1;
  logic [3:0]  fold2;
  logic [2:0]  wd_res;
  logic [YEAR_W-1:0] s3_year;
  logic        s3_leap;
  logic [2:0]  s3_res;

  always_comb begin
    day_sum = s2_sum + 15'(month_start_mod7(month_sel)) +
              15'((month_sel > 4'd2) && s2_leap);
    fold1 = 6'(day_sum[2:0]) + 6'(day_sum[5:3]) + 6'(day_sum[8:6]) +
            6'(day_sum[11:9]) + 6'(day_sum[14:12]);
    fold2 = 4'(fold1[2:0]) + 4'(fold1[5:3]);
    wd_res = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_year <= s2_year;
      s3_leap <= s2_leap;
      s3_res  <= wd_res;
    end
  end

  // Stage 4: offset to the first matching weekday, the Nth one, and the
  // month-length check.
  logic [3:0] wd1, first;
  logic [5:0] day_c;
  logic [DAY_W-1:0] len_c;
  logic       hit;

  always_comb begin
    wd1 = 4'(s3_res) + 4'd1;
    if ({1'b0, target_weekday} >= wd1) begin
      first = 4'(target_weekday) - wd1 + 4'd1;
    end else begin
      first = 4'(target_weekday) + 4'd8 - wd1;
    end
    day_c = 6'(week_ordinal - 3'd1) * 6'd7 + 6'(first);
    len_c = ((month_sel == 4'd2) && s3_leap) ? 5'd29 : month_len(month_sel);
    hit = (s3_year >= EPOCH_YEAR) && (week_ordinal != 3'd0) &&
          (target_weekday != 3'd0) && (day_c <= 6'(len_c));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en4) begin
      rsp_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      year_echo    <= s3_year;
      found        <= hit;
      day_of_month <= hit ? day_c[DAY_W-1:0] : 5'd0;
    end
  end

endmodule

/* sv/nwom_checker.sv */
// Port-level checker for the nth-weekday-of-month top level, with its bind.
// Depends on nwom_pkg.
`timescale 1ns / 1ps

module nwom_checker
  import nwom_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_stall,
  input logic [YEAR_W-1:0] year,
  input logic              rsp_valid,
  input logic              rsp_stall,
  input logic [YEAR_W-1:0] year_echo,
  input logic              found,
  input logic [DAY_W-1:0]  day_of_month
);

  // The pipeline is empty right after a reset edge.
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // A stalled response stays and holds its payload.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(year_echo) &&
                               $stable(found) && $stable(day_of_month))
    else $error("stalled response changed");

  // A miss reports day zero; a hit reports a real day.
  a_day_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (found ? (day_of_month != 5'd0) : (day_of_month == 5'd0)))
    else $error("day does not match found flag");

  // Years before the epoch never find a date.
  a_pre_epoch: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (year_echo < EPOCH_YEAR) |-> !found)
    else $error("date found before epoch");

  // With an empty pipeline and a free output, a transfer is never refused.
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid && !rsp_stall && $past(!rsp_valid) && $past(!rsp_valid, 2) &&
    $past(!rsp_valid, 3) && $past(!req_valid) && $past(!req_valid, 2) &&
    $past(!req_valid, 3) && !$past(rst, 3) |-> !req_stall)
    else $error("stall with empty pipeline");

endmodule

bind nth_weekday_of_month_top nwom_checker u_nwom_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req_valid),
  .req_stall    (req_stall),
  .year         (year),
  .rsp_valid    (rsp_valid),
  .rsp_stall    (rsp_stall),
  .year_echo    (year_echo),
  .found        (found),
  .day_of_month (day_of_month)
);

/* tb/nth_weekday_of_month_checker.sv */
// Checker for the nth-weekday-of-month block: watches all three channels,
// predicts each result from the year and the current calendar settings, and
// compares results in order. Depends on nwom_pkg.
`timescale 1ns / 1ps

module nth_weekday_of_month_checker
  import nwom_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_stall,
  input  logic [YEAR_W-1:0] year,
  input  logic              rsp_valid,
  input  logic              rsp_stall,
  input  logic [YEAR_W-1:0] year_echo,
  input  logic              found,
  input  logic [DAY_W-1:0]  day_of_month,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  output int unsigned       mismatches,
  output int unsigned       outstanding
);

  typedef struct packed {
    logic [YEAR_W-1:0] year_echo;
    logic              found;
    logic [DAY_W-1:0]  day_of_month;
  } month_day_t;

  logic [MONTH_W-1:0] cur_month;
  logic [ORD_W-1:0]   cur_ordinal;
  logic [WDAY_W-1:0]  cur_weekday;
  month_day_t         due_dates[$];
  month_day_t         want;

  // Days from January 1 to the 1st of month m; month 0 stands for any
  // month code outside 1..12 and behaves like January.
  function automatic int unsigned days_before_month(input int unsigned m);
    case (m)
      2:       return 31;
      3:       return 59;
      4:       return 90;
      5:       return 120;
      6:       return 151;
      7:       return 181;
      8:       return 212;
      9:       return 243;
      10:      return 273;
      11:      return 304;
      12:      return 334;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned days_in_month(input int unsigned m);
    case (m)
      2:             return 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  function automatic bit leap_year(input int unsigned y);
    return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
  endfunction

  function automatic int unsigned leaps_through(input int unsigned n);
    return n / 4 - n / 100 + n / 400;
  endfunction

  function automatic month_day_t calc_nth_weekday(input logic [YEAR_W-1:0] y,
                                                  input logic [MONTH_W-1:0] mon,
                                                  input logic [ORD_W-1:0] ord,
                                                  input logic [WDAY_W-1:0] wd);
    int unsigned yr;
    int unsigned m;
    int unsigned n;
    int unsigned len;
    int unsigned wd1;
    int unsigned first;
    int unsigned d;
    month_day_t  r;
    yr = y;
    m = (mon >= 1 && mon <= 12) ? int'(mon) : 0;
    r.year_echo = y;
    r.found = 1'b0;
    r.day_of_month = '0;
    if (yr >= EPOCH_YEAR && ord != 0 && wd != 0) begin
      // Day 0 is January 1 of year 1, a Monday.
      n = 365 * (yr - 1) + leaps_through(yr - 1) + days_before_month(m);
      len = days_in_month(m);
      if (leap_year(yr)) begin
        if (m > 2) n = n + 1;
        if (m == 2) len = 29;
      end
      wd1 = n % 7 + 1;
      if (int'(wd) >= wd1) first = wd - wd1 + 1;
      else first = wd + 8 - wd1;
      d = 7 * (ord - 1) + first;
      if (d <= len) begin
        r.found = 1'b1;
        r.day_of_month = d[DAY_W-1:0];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cur_month   <= 4'd1;
      cur_ordinal <= 3'd1;
      cur_weekday <= 3'd1;
      due_dates.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TARGET_MONTH:   cur_month   <= cfg_data[MONTH_W-1:0];
          CFG_WEEK_ORDINAL:   cur_ordinal <= cfg_data[ORD_W-1:0];
          CFG_TARGET_WEEKDAY: cur_weekday <= cfg_data[WDAY_W-1:0];
          default: ;
        endcase
      end
      if (rsp_valid && !rsp_stall) begin
        if (due_dates.size() == 0) begin
          $error("result for year %0d arrived with no transfer pending", year_echo);
          mismatches = mismatches + 1;
        end else begin
          want = due_dates.pop_front();
          if (year_echo !== want.year_echo) begin
            $error("year_echo: expected %0d, got %0d", want.year_echo, year_echo);
            mismatches = mismatches + 1;
          end
          if (found !== want.found) begin
            $error("found: expected %0d, got %0d (year %0d)", want.found, found,
                   want.year_echo);
            mismatches = mismatches + 1;
          end
          if (day_of_month !== want.day_of_month) begin
            $error("day_of_month: expected %0d, got %0d (year %0d)", want.day_of_month,
                   day_of_month, want.year_echo);
            mismatches = mismatches + 1;
          end
        end
      end
      if (req_valid && !req_stall)
        due_dates.push_back(calc_nth_weekday(year, cur_month, cur_ordinal, cur_weekday));
    end
    outstanding = due_dates.size();
  end

endmodule

/* tb/nth_weekday_of_month_top_test.sv */
// Testbench top for the nth-weekday-of-month block: clock, reset, calendar
// settings and year stimulus, watchdog and verdict. Depends on nwom_pkg,
// nth_weekday_of_month_top and nth_weekday_of_month_checker.
`timescale 1ns / 1ps

module nth_weekday_of_month_top_test;
  import nwom_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 1700;
  localparam int unsigned HOLD_CYCLES    = 80;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam logic [1:0]  CFG_SPARE_INDEX = 2'd3;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_stall;
  logic [YEAR_W-1:0] year = '0;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  logic [YEAR_W-1:0] year_echo;
  logic              found;
  logic [DAY_W-1:0]  day_of_month;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned tx_idle_pct = 13;
  int unsigned rx_idle_pct = 58;
  int unsigned hold_requests = 0;
  int unsigned holds_done = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  always #5 clk = ~clk;

  nth_weekday_of_month_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .year         (year),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .year_echo    (year_echo),
    .found        (found),
    .day_of_month (day_of_month),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  nth_weekday_of_month_checker i_day_check (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .year         (year),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .year_echo    (year_echo),
    .found        (found),
    .day_of_month (day_of_month),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  // Result side: random stall, plus a long hold-off whenever one is requested.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      rsp_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_done != hold_requests) begin
      holds_done <= holds_done + 1;
      hold_left  <= HOLD_CYCLES - 1;
      rsp_stall  <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_year(input logic [YEAR_W-1:0] y);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    year      <= y;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering years and wait until every pending result has come back.
  task automatic drain();
    req_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // The unused upper data bit of the 3-bit registers is randomized on purpose.
  task automatic set_calendar(input logic [MONTH_W-1:0] mon, input logic [ORD_W-1:0] ord,
                              input logic [WDAY_W-1:0] wd, input bit spare);
    drain();
    if (spare) write_reg(CFG_SPARE_INDEX, CFG_W'($urandom));
    write_reg(CFG_TARGET_MONTH, mon);
    write_reg(CFG_WEEK_ORDINAL, {1'($urandom), ord});
    write_reg(CFG_TARGET_WEEKDAY, {1'($urandom), wd});
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [YEAR_W-1:0] pick_year();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 70) return YEAR_W'($urandom_range(9999, 1850));
    else if (k < 80) return YEAR_W'($urandom_range(1849, 0));
    else if (k < 90) return YEAR_W'($urandom_range(16383, 10000));
    else return YEAR_W'($urandom);
  endfunction

  initial begin : stimulus
    int unsigned sent;
    int unsigned phase;
    int unsigned span;
    bit          late_hold;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Settings left at their reset values: epoch edges and the year extremes.
    send_year(14'd0);
    send_year(14'd1849);
    send_year(14'd1850);
    send_year(14'd2000);
    send_year(14'd1900);
    send_year(14'd9999);
    send_year(14'd16383);

    // Fifth Thursday of February exists only in some leap years.
    set_calendar(4'd2, 3'd5, 3'd4, 1'b0);
    send_year(14'd2024);
    send_year(14'd2023);
    send_year(14'd2000);
    send_year(14'd2100);

    // Month codes outside 1..12 behave like January; a zero ordinal or weekday finds nothing.
    set_calendar(4'd0, 3'd5, 3'd7, 1'b0);
    send_year(14'd2030);
    send_year(14'd3000);
    set_calendar(4'd13, 3'd7, 3'd3, 1'b0);
    send_year(14'd2030);
    set_calendar(4'd15, 3'd0, 3'd5, 1'b0);
    send_year(14'd2030);
    set_calendar(4'd12, 3'd5, 3'd0, 1'b0);
    send_year(14'd2030);

    set_calendar(4'd11, 3'd4, 3'd4, 1'b0);
    send_year(14'd2024);
    send_year(14'd1850);
    send_year(14'd16383);
    set_calendar(4'd12, 3'd1, 3'd7, 1'b1);
    send_year(14'd1851);
    send_year(14'd12345);

    sent = 0;
    phase = 0;
    late_hold = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (sent >= RANDOM_ITEMS / 3) begin
        tx_idle_pct = 58;
        rx_idle_pct = 13;
      end
      if ($urandom_range(99) < 80)
        set_calendar(MONTH_W'($urandom_range(12, 1)), ORD_W'($urandom_range(5, 1)),
                     WDAY_W'($urandom_range(7, 1)), $urandom_range(7) == 0);
      else
        set_calendar(MONTH_W'($urandom), ORD_W'($urandom), WDAY_W'($urandom),
                     $urandom_range(7) == 0);
      // Long result hold-offs while years keep coming fill the pipeline.
      if (phase == 1 || (tx_idle_pct == 0 && !late_hold)) begin
        hold_requests = hold_requests + 1;
        if (tx_idle_pct == 0) late_hold = 1'b1;
      end
      span = $urandom_range(100, 10);
      repeat (span) begin
        send_year(pick_year());
        sent = sent + 1;
      end
      phase = phase + 1;
    end

    drain();
    if (mismatches == 0 && outstanding == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

/* filelist.f */
sv/nwom_pkg.sv
sv/nth_weekday_of_month_top.sv
sv/nwom_checker.sv
tb/nth_weekday_of_month_checker.sv
tb/nth_weekday_of_month_top_test.sv
